>>> rtl/core/mltf_pkg.sv
package mltf_pkg;

	localparam int LOCAL_DEPTH  = 16;
	localparam int REMOTE_DEPTH = 16;
	localparam int LCW = $clog2(LOCAL_DEPTH + 1);
	localparam int RCW = $clog2(REMOTE_DEPTH + 1);

	localparam logic [1:0] ACT_DROP   = 2'd0;
	localparam logic [1:0] ACT_SEND   = 2'd1;
	localparam logic [1:0] ACT_INJECT = 2'd2;

	localparam logic [2:0] RSN_NONE     = 3'd0;
	localparam logic [2:0] RSN_DISABLED = 3'd1;
	localparam logic [2:0] RSN_TOO_LONG = 3'd2;
	localparam logic [2:0] RSN_LOCAL    = 3'd3;
	localparam logic [2:0] RSN_EMPTY    = 3'd4;
	localparam logic [2:0] RSN_UNKNOWN  = 3'd5;
	localparam logic [2:0] RSN_HEADER   = 3'd6;
	localparam logic [2:0] RSN_ORDER    = 3'd7;

	localparam logic [1:0] CFG_BRIDGE_EN = 2'd0;
	localparam logic [1:0] CFG_ORDER_EN  = 2'd1;
	localparam logic [1:0] CFG_LOCAL_ID  = 2'd2;
	localparam logic [1:0] CFG_MAX_LEN   = 2'd3;

	localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic        req_type;
		logic [47:0] src_mac;
		logic [47:0] dst_mac;
		logic        too_long;
		logic        disabled;
		logic        header_ok;
		logic [31:0] sender_id;
		logic [31:0] seq_in;
	} item_t;

	localparam int ITEM_W = $bits(item_t);

endpackage

>>> rtl/core/mltf_front.sv
// Accepts items, classifies the cheap checks and pushes them into a two-entry queue.
module mltf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 req_type,
	input  logic [47:0]          src_mac,
	input  logic [47:0]          dst_mac,
	input  logic [15:0]          frame_len,
	input  logic                 header_ok,
	input  logic [31:0]          sender_id,
	input  logic [31:0]          seq_in,
	input  logic                 bridge_en,
	input  logic [15:0]          max_len,
	input  logic                 pop,
	output logic                 q_valid,
	output mltf_pkg::item_t      q_item
);

	mltf_pkg::item_t mem_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            push;
	mltf_pkg::item_t in_item;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rp_q];

	always_comb begin
		in_item.req_type  = req_type;
		in_item.src_mac   = src_mac;
		in_item.dst_mac   = dst_mac;
		in_item.too_long  = frame_len > max_len;
		in_item.disabled  = !bridge_en;
		in_item.header_ok = header_ok;
		in_item.sender_id = sender_id;
		in_item.seq_in    = seq_in;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue overflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("pop from empty queue");
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !push) else $error("push while full");

endmodule

>>> rtl/core/mltf_back.sv
// Executes one queued item per cycle against the address tables.
module mltf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  mltf_pkg::item_t q_item,
	output logic            pop,
	input  logic            order_en,
	input  logic [31:0]     local_id,
	output logic            done,
	output logic [1:0]      action,
	output logic [2:0]      drop_reason,
	output logic [31:0]     tag_counter,
	output logic [31:0]     tag_id,
	output logic            remote_full
);

	logic [47:0] ltab_q [mltf_pkg::LOCAL_DEPTH];
	logic [47:0] rtab_q [mltf_pkg::REMOTE_DEPTH];
	logic [mltf_pkg::LCW-1:0] lcnt_q;
	logic [mltf_pkg::RCW-1:0] rcnt_q;
	logic [31:0] send_q, sid_q, last_q;
	logic        known_q;

	logic lsrc_hit, ldst_hit, rdst_hit, rsrc_hit;
	logic l_learn, r_learn, stamp, drop_t, svr_load, bcast;
	logic [1:0]  act_c;
	logic [2:0]  rsn_c;

	assign pop = q_valid;

	always_comb begin
		lsrc_hit = 1'b0;
		ldst_hit = 1'b0;
		for (int i = 0; i < mltf_pkg::LOCAL_DEPTH; i++) begin
			if (mltf_pkg::LCW'(i) < lcnt_q) begin
				if (ltab_q[i] == q_item.src_mac) lsrc_hit = 1'b1;
				if (ltab_q[i] == q_item.dst_mac) ldst_hit = 1'b1;
			end
		end
		rdst_hit = 1'b0;
		rsrc_hit = 1'b0;
		for (int i = 0; i < mltf_pkg::REMOTE_DEPTH; i++) begin
			if (mltf_pkg::RCW'(i) < rcnt_q) begin
				if (rtab_q[i] == q_item.dst_mac) rdst_hit = 1'b1;
				if (rtab_q[i] == q_item.src_mac) rsrc_hit = 1'b1;
			end
		end
	end

	always_comb begin
		bcast    = (q_item.dst_mac == mltf_pkg::MAC_BCAST);
		act_c    = mltf_pkg::ACT_DROP;
		rsn_c    = mltf_pkg::RSN_NONE;
		stamp    = 1'b0;
		l_learn  = 1'b0;
		r_learn  = 1'b0;
		drop_t   = 1'b0;
		svr_load = 1'b0;
		if (q_item.disabled) begin
			rsn_c = mltf_pkg::RSN_DISABLED;
		end else if (!q_item.req_type) begin
			if (q_item.too_long) begin
				rsn_c = mltf_pkg::RSN_TOO_LONG;
			end else begin
				stamp   = 1'b1;
				l_learn = !lsrc_hit && (lcnt_q < mltf_pkg::LCW'(mltf_pkg::LOCAL_DEPTH));
				// A freshly learned source counts as local for the destination check.
				if (ldst_hit || (l_learn && q_item.src_mac == q_item.dst_mac)) begin
					rsn_c = mltf_pkg::RSN_LOCAL;
				end else if (!bcast && rcnt_q == '0) begin
					rsn_c = mltf_pkg::RSN_EMPTY;
				end else if (!bcast && !rdst_hit) begin
					rsn_c = mltf_pkg::RSN_UNKNOWN;
				end else begin
					act_c = mltf_pkg::ACT_SEND;
				end
			end
		end else begin
			if (!q_item.header_ok) begin
				rsn_c  = mltf_pkg::RSN_HEADER;
				drop_t = 1'b1;
			end else if (!known_q || sid_q != q_item.sender_id) begin
				svr_load = 1'b1;
			end else if (order_en && q_item.seq_in <= last_q) begin
				rsn_c  = mltf_pkg::RSN_ORDER;
				drop_t = 1'b1;
			end
			if (!drop_t) begin
				act_c   = mltf_pkg::ACT_INJECT;
				r_learn = !rsrc_hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && l_learn) ltab_q[lcnt_q[$clog2(mltf_pkg::LOCAL_DEPTH)-1:0]] <= q_item.src_mac;
		if (q_valid && r_learn && rcnt_q < mltf_pkg::RCW'(mltf_pkg::REMOTE_DEPTH))
			rtab_q[rcnt_q[$clog2(mltf_pkg::REMOTE_DEPTH)-1:0]] <= q_item.src_mac;
		if (q_valid) begin
			action      <= act_c;
			drop_reason <= rsn_c;
			tag_counter <= stamp ? send_q : 32'd0;
			tag_id      <= (act_c == mltf_pkg::ACT_SEND) ? local_id : 32'd0;
			remote_full <= r_learn && rcnt_q >= mltf_pkg::RCW'(mltf_pkg::REMOTE_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcnt_q  <= '0;
			rcnt_q  <= '0;
			send_q  <= 32'd0;
			sid_q   <= 32'd0;
			last_q  <= 32'd0;
			known_q <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= q_valid;
			if (q_valid) begin
				if (stamp) send_q <= send_q + 32'd1;
				if (l_learn) lcnt_q <= lcnt_q + mltf_pkg::LCW'(1);
				if (r_learn && rcnt_q < mltf_pkg::RCW'(mltf_pkg::REMOTE_DEPTH))
					rcnt_q <= rcnt_q + mltf_pkg::RCW'(1);
				if (svr_load) begin
					sid_q   <= q_item.sender_id;
					known_q <= 1'b1;
				end
				if (act_c == mltf_pkg::ACT_INJECT && order_en) last_q <= q_item.seq_in;
			end
		end
	end

	a_lcnt: assert property (@(posedge clk) disable iff (!arst_n)
		lcnt_q <= mltf_pkg::LCW'(mltf_pkg::LOCAL_DEPTH)) else $error("local count");
	a_rcnt: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= mltf_pkg::RCW'(mltf_pkg::REMOTE_DEPTH)) else $error("remote count");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && remote_full) |-> (action == mltf_pkg::ACT_INJECT)) else $error("full flag");

endmodule

>>> rtl/core/mac_learning_tunnel_filter.sv
// Learning bridge filter for frames carried over a tunnel.
// Items enter on start while busy is low: req_type, addresses, frame_len,
// header_ok, sender_id and seq_in. A front stage checks the length and the
// enable and places the item in a two-entry queue; a back stage matches the
// addresses against the 16-entry local and remote tables, learns sources and
// produces one result per item.
// Each result appears for one cycle with done high: action, drop_reason,
// tag_counter, tag_id and remote_full. An accepted item is written into the
// queue, and the back stage registers its result; one item per cycle is
// sustained, set by the parallel combinational table compare in the back stage.
// Registers are written on cfg_valid and cfg_ready (always ready) with
// cfg_index 0 bridge_enable, 1 order_enable, 2 local_id, 3 max_frame_len.
// Reset empties both tables and the queue and restores register defaults.
// The receiver cannot stall; results are never held.
module mac_learning_tunnel_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [47:0] src_mac,
	input  logic [47:0] dst_mac,
	input  logic [15:0] frame_len,
	input  logic        header_ok,
	input  logic [31:0] sender_id,
	input  logic [31:0] seq_in,
	output logic        done,
	output logic [1:0]  action,
	output logic [2:0]  drop_reason,
	output logic [31:0] tag_counter,
	output logic [31:0] tag_id,
	output logic        remote_full,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic            bridge_en_q, order_en_q;
	logic [31:0]     local_id_q;
	logic [15:0]     max_len_q;
	logic            q_valid, pop;
	mltf_pkg::item_t q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bridge_en_q <= 1'b1;
			order_en_q  <= 1'b0;
			local_id_q  <= 32'd1;
			max_len_q   <= 16'd1518;
		end else if (cfg_valid) begin
			case (cfg_index)
				mltf_pkg::CFG_BRIDGE_EN: bridge_en_q <= cfg_data[0];
				mltf_pkg::CFG_ORDER_EN:  order_en_q  <= cfg_data[0];
				mltf_pkg::CFG_LOCAL_ID:  local_id_q  <= cfg_data;
				mltf_pkg::CFG_MAX_LEN:   max_len_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	mltf_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .src_mac(src_mac), .dst_mac(dst_mac),
		.frame_len(frame_len), .header_ok(header_ok), .sender_id(sender_id),
		.seq_in(seq_in), .bridge_en(bridge_en_q), .max_len(max_len_q),
		.pop(pop), .q_valid(q_valid), .q_item(q_item)
	);

	mltf_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item), .pop(pop),
		.order_en(order_en_q), .local_id(local_id_q), .done(done),
		.action(action), .drop_reason(drop_reason), .tag_counter(tag_counter),
		.tag_id(tag_id), .remote_full(remote_full)
	);

endmodule
